// ===== rtl/core/heightfield_height_query_assert.svh =====
// ----------------------------------------------------------------------------
// Heightfield height query assertion macros
// Concurrent checks on clk with asynchronous active-low reset arst_n; empty
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HEIGHTFIELD_HEIGHT_QUERY_ASSERT_SVH
`define HEIGHTFIELD_HEIGHT_QUERY_ASSERT_SVH

`ifndef SYNTHESIS

// Property holds at every edge outside reset
`define HHQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("heightfield query: check failed");

// Consequent holds in the cycle after the antecedent
`define HHQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("heightfield query: sequence check failed");

`else

`define HHQ_ASSERT(lbl, prop)
`define HHQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/hhq_pkg.sv =====
// ----------------------------------------------------------------------------
// Heightfield height query package
// Request and result types, register indexes, sequencer states and the
// fixed-point constants shared by the heightfield query block.
// ----------------------------------------------------------------------------
`default_nettype none

package hhq_pkg;

	// Fixed-point and store geometry
	localparam int unsigned FRAC_BITS = 8;
	localparam int unsigned ADDR_W    = 16;
	localparam int unsigned HGT_W     = 16;
	localparam int unsigned DIM_W     = 9;
	localparam int unsigned WGT_W     = FRAC_BITS + 1;
	localparam int unsigned ACC_W     = HGT_W + WGT_W;

	localparam logic [DIM_W-1:0] DIM_MIN = 9'd2;
	localparam logic [DIM_W-1:0] DIM_MAX = 9'd256;
	localparam logic [WGT_W-1:0] ONE     = 9'd256;

	// Request types
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [15:0]        sample_index;
		logic [15:0]        sample_height;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic [15:0] height_out;
		logic        inside_res;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_READ,
		S_DRAIN,
		S_OUT
	} state_t;

	// Saturate a grid dimension to the supported range
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		r = d;
		if (d < DIM_MIN) r = DIM_MIN;
		else if (d > DIM_MAX) r = DIM_MAX;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/heightfield_height_query.sv =====
// ----------------------------------------------------------------------------
// Heightfield height query
// Height sample store with triangle interpolation of terrain height at a
// fixed-point world position.
// ----------------------------------------------------------------------------
// A load request writes one 16-bit height sample into the 65536-entry store
// while the block is idle; the next request may follow at once. A query
// request that falls inside the grid is taken, then the block stalls its
// input while it locates the cell and forms the triangle weights, reads the
// four corner heights in turn through the store's single read port, empties
// the read/multiply/accumulate pipeline behind its one shared multiplier, and
// places the result in the output register. A query that falls outside skips
// the reads and the drain, and stalls the input while it locates the cell and
// places the result. The output step stretches for as long as an earlier
// result is still held, stalled, in the output register. A finished result
// may wait in that register while the next request is accepted. Store
// entries are undefined until loaded and there is no clearing pass after
// reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "heightfield_height_query_assert.svh"

module heightfield_height_query (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  hhq_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  wire                out_stall,
	output hhq_pkg::out_item_t out_data,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire                cfg_index,
	input  wire  [8:0]         cfg_data
);

	import hhq_pkg::*;

	state_t state_q, state_d;

	logic [DIM_W-1:0] grid_width_q, grid_height_q;
	logic [DIM_W-1:0] wc, hc, wm1, hm1;

	logic signed [23:0] px_q, pz_q;
	logic               inside_q;
	logic [ADDR_W-1:0]  base_q;
	logic [WGT_W-1:0]   wgt_q [4];
	logic [1:0]         cnt_q;

	logic [HGT_W-1:0]   height_grid_q [0:65535];
	logic [HGT_W-1:0]   rd_data_s1;
	logic               rvld_s1;
	logic [1:0]         rk_s1;
	logic [ACC_W-1:0]   prod_s2;
	logic               pvld_s2;
	logic [ACC_W-1:0]   acc_q;

	logic               out_valid_q;
	out_item_t          out_data_q;

	logic in_acc, mem_we, calc_en, rd_en, out_load;

	logic signed [25:0] t_c;
	logic [14:0]        col_c;
	logic [16:0]        row_c;
	logic               inside_c;
	logic [WGT_W-1:0]   u_c, v_c;
	logic [9:0]         uv_c, w0_lo, w3_hi;
	logic               lower_c;
	logic [16:0]        base_mul, base_c;
	logic               off_w, off_1;
	logic [ADDR_W-1:0]  rd_addr;
	logic [HGT_W-1:0]   res_c;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= DIM_MAX;
			grid_height_q <= DIM_MAX;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_GRID_WIDTH) grid_width_q <= cfg_data;
			else grid_height_q <= cfg_data;
		end
	end

	assign wc  = clamp_dim(grid_width_q);
	assign hc  = clamp_dim(grid_height_q);
	assign wm1 = wc - 9'd1;
	assign hm1 = hc - 9'd1;

	// Accept requests; loads go straight to the store
	assign in_acc = in_valid && !in_stall;
	assign mem_we = in_acc && (in_data.req_type == REQ_LOAD);

	always_ff @(posedge clk) begin
		if (in_acc && (in_data.req_type == REQ_QUERY)) begin
			px_q <= in_data.pos_x;
			pz_q <= in_data.pos_z;
		end
	end

	// Locate the cell, test bounds and form the triangle weights
	always_comb begin
		t_c      = $signed({9'd0, hm1, 8'd0}) - $signed({{2{pz_q[23]}}, pz_q});
		col_c    = px_q[22:FRAC_BITS];
		row_c    = t_c[24:FRAC_BITS];
		inside_c = !px_q[23] && !t_c[25]
			&& (col_c < {6'd0, wm1}) && (row_c < {8'd0, hm1});
		u_c      = {1'b0, px_q[FRAC_BITS-1:0]};
		v_c      = ONE - {1'b0, t_c[FRAC_BITS-1:0]};
		uv_c     = {1'b0, u_c} + {1'b0, v_c};
		lower_c  = (uv_c <= {1'b0, ONE});
		w0_lo    = {1'b0, ONE} - uv_c;
		w3_hi    = uv_c - {1'b0, ONE};
		base_mul = {8'd0, wc} * {9'd0, row_c[7:0]};
		base_c   = base_mul + {9'd0, col_c[7:0]};
	end

	always_ff @(posedge clk) begin
		if (calc_en) begin
			inside_q <= inside_c;
			base_q   <= base_c[ADDR_W-1:0];
			if (lower_c) begin
				wgt_q[0] <= w0_lo[WGT_W-1:0];
				wgt_q[1] <= v_c;
				wgt_q[2] <= u_c;
				wgt_q[3] <= '0;
			end else begin
				wgt_q[0] <= '0;
				wgt_q[1] <= ONE - u_c;
				wgt_q[2] <= ONE - v_c;
				wgt_q[3] <= w3_hi[WGT_W-1:0];
			end
		end
	end

	// Corner address: 0 below-left, 1 left, 2 below-right, 3 right
	assign off_w   = (cnt_q == 2'd0) || (cnt_q == 2'd2);
	assign off_1   = (cnt_q == 2'd2) || (cnt_q == 2'd3);
	assign rd_addr = base_q + (off_w ? {7'd0, wc} : 16'd0) + {15'd0, off_1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (calc_en) cnt_q <= '0;
		else if (rd_en) cnt_q <= cnt_q + 2'd1;
	end

	// Height store
	always_ff @(posedge clk) begin
		if (mem_we) height_grid_q[in_data.sample_index] <= in_data.sample_height;
		if (rd_en) rd_data_s1 <= height_grid_q[rd_addr];
	end

	// Advance the read, multiply and accumulate pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
			pvld_s2 <= 1'b0;
		end else begin
			rvld_s1 <= rd_en;
			pvld_s2 <= rvld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) rk_s1 <= cnt_q;
		if (rvld_s1) prod_s2 <= {9'd0, rd_data_s1} * {16'd0, wgt_q[rk_s1]};
		if (calc_en) acc_q <= '0;
		else if (pvld_s2) acc_q <= acc_q + prod_s2;
	end

	// Drop the fraction and saturate
	assign res_c = acc_q[ACC_W-1] ? 16'hFFFF : acc_q[ACC_W-2:FRAC_BITS];

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		calc_en  = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && (in_data.req_type == REQ_QUERY)) state_d = S_CALC;
			end
			S_CALC: begin
				calc_en = 1'b1;
				state_d = inside_c ? S_READ : S_OUT;
			end
			S_READ: begin
				rd_en = 1'b1;
				if (cnt_q == 2'd3) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!rvld_s1 && !pvld_s2) state_d = S_OUT;
			end
			S_OUT: begin
				out_load = !out_valid_q || !out_stall;
				if (out_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.height_out <= inside_q ? res_c : '0;
			out_data_q.inside_res <= inside_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Checks
	`HHQ_ASSERT(a_read_from_seq, rvld_s1 |-> ($past(state_q) == S_READ))
	`HHQ_ASSERT(a_out_pipe_empty, (state_q == S_OUT) |-> (!rvld_s1 && !pvld_s2))
	`HHQ_ASSERT(a_out_rise_src, $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
	`HHQ_ASSERT(a_outside_zero, (out_valid && !out_data.inside_res) |-> (out_data.height_out == 16'd0))
	`HHQ_ASSERT_NEXT(a_calc_next, state_q == S_CALC, (state_q == S_READ) || (state_q == S_OUT))

endmodule

`default_nettype wire
